// File: rtl/core/sd64_pkg.sv
package sd64_pkg;

	localparam int MAG_W      = 64;
	localparam int NUM_DIGITS = 19;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int CHAR_W     = 6;
	localparam int EXP_W      = 5;
	localparam int BIT_CNT_W  = 6;

	localparam logic [CHAR_W-1:0]    DIGIT_BASE = 6'd48;
	localparam logic [EXP_W-1:0]     TOP_EXP    = 5'(NUM_DIGITS - 1);
	localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(MAG_W - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic shift;
	} dabble_ctrl_t;

endpackage

// File: rtl/core/sd64_dabble.sv
module sd64_dabble (
	input  logic                                  clk,
	input  sd64_pkg::dabble_ctrl_t                ctrl,
	input  logic [sd64_pkg::MAG_W-1:0]            mag,
	output logic [sd64_pkg::DIGIT_W-1:0]          top_digit
);
	import sd64_pkg::*;

	logic [MAG_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	// add 3 to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
			end else begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			bin_q <= {bin_q[MAG_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[MAG_W-1]};
		end else if (ctrl.shift) begin
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];

endmodule

// File: rtl/core/signed_int64_to_decimal_digits_core.sv
// Converts one signed 64-bit integer per request into its decimal digits as ASCII,
// most significant first, without leading zeros; zero gives a single '0'. Each digit
// carries the sign, the exponent of the leading digit and a last flag. A value goes
// through the shift-and-add-3 loop, one magnitude bit per cycle, then drops leading
// zeros, then loads its digits into the output register one at a time as the output
// allows. The input is stalled from acceptance until the last digit has been loaded
// into the output register.
module signed_int64_to_decimal_digits_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [sd64_pkg::MAG_W-1:0]    value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [sd64_pkg::CHAR_W-1:0]          digit_char,
	output logic [sd64_pkg::EXP_W-1:0]           exponent,
	output logic                                 negative,
	output logic                                 last
);
	import sd64_pkg::*;

	state_t                 state_q, state_d;
	logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
	logic [EXP_W-1:0]       exp_q, exp_d;
	logic [EXP_W-1:0]       rem_q, rem_d;
	logic                   neg_q;
	logic                   out_valid_q, out_valid_d;
	logic                   out_load;
	logic [CHAR_W-1:0]      digit_char_q;
	logic [EXP_W-1:0]       exponent_q;
	logic                   negative_q;
	logic                   last_q;
	logic                   in_accept;
	logic [MAG_W-1:0]       mag;
	logic [DIGIT_W-1:0]     top_digit;
	dabble_ctrl_t           ctrl;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign mag       = value[MAG_W-1] ? (~value + 1'b1) : value;

	sd64_dabble u_dabble (
		.clk       (clk),
		.ctrl      (ctrl),
		.mag       (mag),
		.top_digit (top_digit)
	);

	always_comb begin
		state_d     = state_q;
		bit_cnt_d   = bit_cnt_q;
		exp_d       = exp_q;
		rem_d       = rem_q;
		out_valid_d = out_valid_q && out_stall;
		out_load    = 1'b0;
		ctrl        = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					ctrl.load = 1'b1;
					bit_cnt_d = LAST_BIT;
					exp_d     = TOP_EXP;
					state_d   = ST_CONV;
				end
			end
			ST_CONV: begin
				ctrl.step = 1'b1;
				bit_cnt_d = bit_cnt_q - 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (top_digit == '0 && exp_q != '0) begin
					ctrl.shift = 1'b1;
					exp_d      = exp_q - 1'b1;
				end else begin
					rem_d   = exp_q;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					ctrl.shift  = 1'b1;
					if (rem_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						rem_d = rem_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		bit_cnt_q <= bit_cnt_d;
		exp_q     <= exp_d;
		rem_q     <= rem_d;
		if (in_accept) begin
			neg_q <= value[MAG_W-1];
		end
		if (out_load) begin
			digit_char_q <= DIGIT_BASE + CHAR_W'(top_digit);
			exponent_q   <= exp_q;
			negative_q   <= neg_q;
			last_q       <= (rem_q == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign exponent   = exponent_q;
	assign negative   = negative_q;
	assign last       = last_q;

endmodule

// File: bench/tb_signed_int64_to_decimal_digits_core.sv
`timescale 1ns / 100ps

class digit_scoreboard;

	typedef struct {
		logic [sd64_pkg::CHAR_W-1:0] digit_char;
		logic [sd64_pkg::EXP_W-1:0]  exponent;
		logic                        negative;
		logic                        last;
	} digit_t;

	digit_t expected_digits[$];
	int     n_fail;

	function new();
		n_fail = 0;
	endfunction

	function int pending();
		return expected_digits.size();
	endfunction

	// Expand one accepted request into its digits, most significant first.
	function void note_value(logic [63:0] v);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] pow;
		logic [63:0] rest;
		logic [3:0]  dig[19];
		int          len;
		digit_t      d;
		neg = v[63];
		mag = neg ? (~v + 64'd1) : v;
		len = 1;
		pow = 64'd10;
		while (len < sd64_pkg::NUM_DIGITS && mag >= pow) begin
			len++;
			if (len < sd64_pkg::NUM_DIGITS)
				pow = pow * 64'd10;
		end
		rest = mag;
		for (int k = 0; k < len; k++) begin
			dig[k] = 4'(rest % 64'd10);
			rest = rest / 64'd10;
		end
		for (int k = len - 1; k >= 0; k--) begin
			d.digit_char = sd64_pkg::CHAR_W'(48 + dig[k]);
			d.exponent   = sd64_pkg::EXP_W'(len - 1);
			d.negative   = neg;
			d.last       = (k == 0);
			expected_digits.push_back(d);
		end
	endfunction

	function void check_digit(logic [sd64_pkg::CHAR_W-1:0] c, logic [sd64_pkg::EXP_W-1:0] e,
			logic n, logic l);
		digit_t d;
		if (expected_digits.size() == 0) begin
			n_fail++;
			if (n_fail <= 10)
				$display("unexpected digit: char %0d exp %0d neg %0b last %0b", c, e, n, l);
			return;
		end
		d = expected_digits.pop_front();
		if (c !== d.digit_char || e !== d.exponent || n !== d.negative || l !== d.last) begin
			n_fail++;
			if (n_fail <= 10)
				$display("digit mismatch: expected char %0d exp %0d neg %0b last %0b,",
					d.digit_char, d.exponent, d.negative, d.last,
					" got char %0d exp %0d neg %0b last %0b", c, e, n, l);
		end
	endfunction

endclass

module tb_signed_int64_to_decimal_digits_core;

	logic                               clk        = 1'b0;
	logic                               arst_n     = 1'b0;
	logic                               in_valid   = 1'b0;
	logic                               in_stall;
	logic signed [sd64_pkg::MAG_W-1:0]  value      = '0;
	logic                               out_valid;
	logic                               out_stall  = 1'b0;
	logic [sd64_pkg::CHAR_W-1:0]        digit_char;
	logic [sd64_pkg::EXP_W-1:0]         exponent;
	logic                               negative;
	logic                               last;

	digit_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	signed_int64_to_decimal_digits_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.exponent   (exponent),
		.negative   (negative),
		.last       (last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_digit(digit_char, exponent, negative, last);
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic logic [63:0] pow10(int n);
		logic [63:0] p;
		p = 64'd1;
		for (int k = 0; k < n; k++)
			p = p * 64'd10;
		return p;
	endfunction

	function automatic logic [63:0] pick_value();
		logic [63:0] mag;
		logic [63:0] p;
		int          n;
		case ($urandom_range(3))
			0: return {$urandom, $urandom};
			1: begin
				// magnitude of a chosen digit count, 1 to 18 digits
				n = $urandom_range(18, 1);
				p = pow10(n - 1);
				mag = p + ({$urandom, $urandom} % (p * 64'd9));
			end
			2: begin
				// around a power of ten
				n = $urandom_range(18);
				mag = pow10(n) + 64'($urandom_range(2)) - 64'd1;
			end
			default: mag = 64'($urandom_range(999));
		endcase
		return $urandom_range(1) ? (~mag + 64'd1) : mag;
	endfunction

	task automatic send_value(logic [63:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_value(v);
	endtask

	// Drop valid and hold until every pending digit has come out.
	task automatic drain_digits();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin
		logic [63:0] directed[$];
		sb = new();
		directed = '{
			64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
			64'd999999999999999999, 64'd1000000000000000000, -64'sd1000000000000000000,
			-64'sd999999999999999999, 64'd123456789, -64'sd987654321,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF,
			64'd4294967296, -64'sd9000000000000000001
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 8;
		recv_idle_pct = 65;
		foreach (directed[i])
			send_value(directed[i]);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 8;  recv_idle_pct = 65; end
				1: begin send_idle_pct = 65; recv_idle_pct = 8;  end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int i = 0; i < 67; i++)
				send_value(pick_value());
			if (phase == 0)
				drain_digits();
		end

		drain_digits();
		repeat (100) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0d expected digits never arrived", sb.pending());
		if (sb.n_fail == 0 && sb.pending() == 0)
			$display("tb_signed_int64_to_decimal_digits_core: done, clean");
		else
			$display("tb_signed_int64_to_decimal_digits_core: done, errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout waiting for digits");
		$display("tb_signed_int64_to_decimal_digits_core: done, errors");
		$finish;
	end

endmodule
